@@ rtl/core/ptp_pkg.sv @@
// Types and constants shared by the present time predictor.
package ptp_pkg;

  localparam int unsigned CfgIdxW = 8;

  localparam logic [CfgIdxW-1:0] CfgRefreshInterval = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgRefreshDuration = 8'd1;
  localparam logic [CfgIdxW-1:0] CfgPropsKnown      = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgTimingActive    = 8'd3;

  localparam logic [2:0] DomStageLocal = 3'd5;

  localparam logic [1:0] AnchorNone       = 2'd0;
  localparam logic [1:0] AnchorDequeued   = 2'd1;
  localparam logic [1:0] AnchorFirstPixel = 2'd2;
  localparam logic [1:0] AnchorUnused     = 2'd3;

  typedef enum logic [1:0] {
    MODE_FEEDBACK = 2'd0,
    MODE_PREDICT  = 2'd1,
    MODE_DOMAIN   = 2'd2,
    MODE_RESTART  = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e       mode;
    logic        report_complete;
    logic [63:0] present_id;
    logic [2:0]  domain_code;
    logic [63:0] domain_ident;
    logic [63:0] first_pixel_time;
    logic [63:0] dequeued_time;
    logic [63:0] queue_end_time;
    logic [1:0]  anchor_select;
  } in_t;

  typedef struct packed {
    logic [63:0] predicted_id;
    logic [63:0] target_time;
    logic        align_flag;
    logic        inactive_error;
    logic [63:0] current_domain_id;
    logic [1:0]  target_stage;
    logic [63:0] newest_seen_id;
    logic        margin_valid;
    logic [63:0] margin_ns;
    logic        baseline_valid;
  } out_t;

  // state view carried down the pipe with each beat
  typedef struct packed {
    logic [63:0] pred_id;
    logic        refused;
    logic [63:0] dom_id;
    logic [1:0]  stage;
    logic [63:0] newest;
    logic        margin_valid;
    logic [63:0] margin;
    logic        base_valid;
  } snap_t;

  typedef struct packed {
    snap_t       snap;
    logic        timed;
    logic [63:0] delta;
    logic [63:0] cad;
    logic [63:0] base_time;
  } p1_t;

  typedef struct packed {
    snap_t       snap;
    logic        timed;
    logic [63:0] ll;
    logic [31:0] lh;
    logic [31:0] hl;
    logic [63:0] base_time;
  } p2_t;

endpackage

@@ rtl/core/present_time_predictor.sv @@
// Present time predictor: state update, split target multiply and result register.
// Each accepted beat is registered in p1_q, then p2_q, then out_q, which drives out_data_o with out_valid_o.
// Throughput: one beat per cycle while the output is not stalled; a stalled output backs up through three stages.
// The 64-bit cadence product is built from three 32x32 partial products in stage two.
// Reset clears all predictor state and the configuration registers to zero.
module present_time_predictor (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  ptp_pkg::in_t               in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output ptp_pkg::out_t              out_data_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [ptp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]                cfg_data_i
);

  logic [63:0] interval_q, duration_q;
  logic        props_q, active_q;

  logic [63:0] next_id_q, next_id_d;
  logic        base_valid_q, base_valid_d;
  logic [63:0] base_id_q, base_id_d;
  logic [63:0] base_time_q, base_time_d;
  logic        margin_known_q, margin_known_d;
  logic [63:0] margin_q, margin_d;
  logic [63:0] newest_q, newest_d;
  logic [2:0]  dom_q, dom_d;
  logic [63:0] dom_id_q, dom_id_d;
  logic        local_q, local_d;
  logic [1:0]  anchor_q, anchor_d;

  logic        v1_q, v2_q, v3_q;
  logic        adv1, adv2, adv3, accept;
  ptp_pkg::p1_t  p1_q, p1_d;
  ptp_pkg::p2_t  p2_q, p2_d;
  ptp_pkg::out_t out_q, out_d;

  logic [63:0] stamp, nid;
  logic        loc;
  logic [1:0]  anc;
  logic [31:0] mid;
  logic [63:0] prod;
  logic [64:0] sum;

  assign cfg_ready_o = 1'b1;

  assign adv3       = !v3_q || !out_stall_i;
  assign adv2       = !v2_q || adv3;
  assign adv1       = !v1_q || adv2;
  assign in_stall_o = !adv1;
  assign accept     = in_valid_i && adv1;

  assign out_valid_o = v3_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= '0;
      duration_q <= '0;
      props_q    <= 1'b0;
      active_q   <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        ptp_pkg::CfgRefreshInterval: interval_q <= cfg_data_i;
        ptp_pkg::CfgRefreshDuration: duration_q <= cfg_data_i;
        ptp_pkg::CfgPropsKnown:      props_q    <= cfg_data_i[0];
        ptp_pkg::CfgTimingActive:    active_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // stage one: state update and multiply operands
  always_comb begin
    next_id_d      = next_id_q;
    base_valid_d   = base_valid_q;
    base_id_d      = base_id_q;
    base_time_d    = base_time_q;
    margin_known_d = margin_known_q;
    margin_d       = margin_q;
    newest_d       = newest_q;
    dom_d          = dom_q;
    dom_id_d       = dom_id_q;
    local_d        = local_q;
    anchor_d       = anchor_q;
    stamp          = '0;
    nid            = next_id_q + 64'd1;
    loc            = (in_data_i.domain_code == ptp_pkg::DomStageLocal);
    anc            = (in_data_i.anchor_select == ptp_pkg::AnchorUnused || !loc)
                     ? ptp_pkg::AnchorNone : in_data_i.anchor_select;
    p1_d           = '0;
    p1_d.cad       = (interval_q != '0) ? interval_q : duration_q;
    p1_d.base_time = base_time_q;
    p1_d.delta     = nid - base_id_q;

    unique case (in_data_i.mode)
      ptp_pkg::MODE_FEEDBACK: begin
        if (in_data_i.report_complete) begin
          if (in_data_i.present_id > newest_q) newest_d = in_data_i.present_id;
          if (in_data_i.domain_code != dom_q || in_data_i.domain_ident != dom_id_q) begin
            if (!local_q && !loc) begin
              dom_d        = in_data_i.domain_code;
              dom_id_d     = in_data_i.domain_ident;
              base_valid_d = 1'b0;
              base_id_d    = '0;
              base_time_d  = '0;
            end else if (local_q) begin
              base_valid_d = 1'b0;
              base_id_d    = '0;
              base_time_d  = '0;
            end
          end else begin
            if (local_q) begin
              if (anchor_q == ptp_pkg::AnchorDequeued) stamp = in_data_i.dequeued_time;
              else if (anchor_q == ptp_pkg::AnchorFirstPixel)
                stamp = in_data_i.first_pixel_time;
            end else begin
              stamp = (in_data_i.first_pixel_time != '0) ? in_data_i.first_pixel_time
                                                         : in_data_i.dequeued_time;
            end
            if (in_data_i.present_id != '0 && stamp != '0) begin
              base_valid_d = 1'b1;
              base_id_d    = in_data_i.present_id;
              base_time_d  = stamp;
            end
            if (!local_q && in_data_i.queue_end_time != '0 && in_data_i.dequeued_time != '0
                && in_data_i.dequeued_time >= in_data_i.queue_end_time) begin
              margin_known_d = 1'b1;
              margin_d       = in_data_i.dequeued_time - in_data_i.queue_end_time;
            end
          end
        end
      end
      ptp_pkg::MODE_PREDICT: begin
        if (!active_q) begin
          p1_d.snap.refused = 1'b1;
        end else begin
          next_id_d         = nid;
          p1_d.snap.pred_id = nid;
          p1_d.timed        = base_valid_q && props_q && (nid > base_id_q);
        end
      end
      ptp_pkg::MODE_DOMAIN: begin
        if (in_data_i.domain_code != dom_q || in_data_i.domain_ident != dom_id_q
            || loc != local_q || anc != anchor_q) begin
          dom_d        = in_data_i.domain_code;
          dom_id_d     = in_data_i.domain_ident;
          local_d      = loc;
          anchor_d     = anc;
          base_valid_d = 1'b0;
          base_id_d    = '0;
          base_time_d  = '0;
        end
      end
      ptp_pkg::MODE_RESTART: begin
        next_id_d      = '0;
        base_valid_d   = 1'b0;
        base_id_d      = '0;
        base_time_d    = '0;
        margin_known_d = 1'b0;
        margin_d       = '0;
      end
      default: ;
    endcase

    p1_d.snap.dom_id       = dom_id_d;
    p1_d.snap.stage        = local_d ? anchor_d : ptp_pkg::AnchorNone;
    p1_d.snap.newest       = newest_d;
    p1_d.snap.margin_valid = margin_known_d;
    p1_d.snap.margin       = margin_d;
    p1_d.snap.base_valid   = base_valid_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_id_q      <= '0;
      base_valid_q   <= 1'b0;
      base_id_q      <= '0;
      base_time_q    <= '0;
      margin_known_q <= 1'b0;
      margin_q       <= '0;
      newest_q       <= '0;
      dom_q          <= '0;
      dom_id_q       <= '0;
      local_q        <= 1'b0;
      anchor_q       <= ptp_pkg::AnchorNone;
    end else if (accept) begin
      next_id_q      <= next_id_d;
      base_valid_q   <= base_valid_d;
      base_id_q      <= base_id_d;
      base_time_q    <= base_time_d;
      margin_known_q <= margin_known_d;
      margin_q       <= margin_d;
      newest_q       <= newest_d;
      dom_q          <= dom_d;
      dom_id_q       <= dom_id_d;
      local_q        <= local_d;
      anchor_q       <= anchor_d;
    end
  end

  // stage two: partial products, only the low 64 bits of the product matter
  always_comb begin
    p2_d.snap      = p1_q.snap;
    p2_d.timed     = p1_q.timed;
    p2_d.base_time = p1_q.base_time;
    p2_d.ll        = 64'(p1_q.delta[31:0]) * 64'(p1_q.cad[31:0]);
    p2_d.lh        = 32'(p1_q.delta[31:0] * p1_q.cad[63:32]);
    p2_d.hl        = 32'(p1_q.delta[63:32] * p1_q.cad[31:0]);
  end

  // stage three: sum, wrap check, result
  always_comb begin
    mid                     = p2_q.lh + p2_q.hl;
    prod                    = p2_q.ll + {mid, 32'd0};
    sum                     = {1'b0, p2_q.base_time} + {1'b0, prod};
    out_d.predicted_id      = p2_q.snap.pred_id;
    out_d.target_time       = (p2_q.timed && !sum[64]) ? sum[63:0] : '0;
    out_d.align_flag        = p2_q.timed && !sum[64] && (sum[63:0] != '0);
    out_d.inactive_error    = p2_q.snap.refused;
    out_d.current_domain_id = p2_q.snap.dom_id;
    out_d.target_stage      = p2_q.snap.stage;
    out_d.newest_seen_id    = p2_q.snap.newest;
    out_d.margin_valid      = p2_q.snap.margin_valid;
    out_d.margin_ns         = p2_q.snap.margin;
    out_d.baseline_valid    = p2_q.snap.base_valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= accept;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) p1_q <= p1_d;
    if (adv2 && v1_q) p2_q <= p2_d;
    if (adv3 && v2_q) out_q <= out_d;
  end

  a_timed_has_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && p1_q.timed |-> p1_q.snap.pred_id != '0)
    else $error("timed beat without predicted id");

  a_refused_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.inactive_error |->
      out_data_o.predicted_id == '0 && out_data_o.target_time == '0)
    else $error("refused beat carries a prediction");

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.mode == ptp_pkg::MODE_RESTART |=>
      !base_valid_q && !margin_known_q && next_id_q == '0)
    else $error("restart left state behind");

  a_anchor_global: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !local_q |-> anchor_q == ptp_pkg::AnchorNone)
    else $error("anchor set outside stage-local domain");

  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && v2_q && v3_q && out_stall_i |-> in_stall_o)
    else $error("input taken while pipe is full");

endmodule
